>>> rtl/slt_pkg.sv
// Package for the shell line tokenizer: types, character codes and helper functions.
`timescale 1ns / 1ps

package slt_pkg;

  localparam int QueueDepth = 4;
  localparam int MaxRes     = 3;

  localparam logic [1:0] AddrExitStatus = 2'd0;

  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0d;
  localparam logic [7:0] ChLf     = 8'h0a;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChQmark  = 8'h3f;
  localparam logic [7:0] ChLowerN = 8'h6e;
  localparam logic [7:0] ChLowerT = 8'h74;
  localparam logic [7:0] ChZero   = 8'h30;

  typedef enum logic [1:0] {
    K_CHAR      = 2'd0,
    K_TOKEN_END = 2'd1,
    K_LINE_DONE = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    M_IDLE       = 4'd0,
    M_TOKEN      = 4'd1,
    M_TOK_BS     = 4'd2,
    M_TOK_DOLLAR = 4'd3,
    M_SQ         = 4'd4,
    M_DQ         = 4'd5,
    M_DQ_BS      = 4'd6,
    M_DQ_DOLLAR  = 4'd7,
    M_COMMENT    = 4'd8
  } mode_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
  } res_t;

  // All results caused by one input byte, in order.
  typedef struct packed {
    logic [1:0]       cnt;
    res_t [MaxRes-1:0] ent;
  } desc_t;

  function automatic desc_t add_res(desc_t d, kind_t kind, logic [7:0] ch);
    desc_t r;
    r = d;
    if (d.cnt != 2'd3) begin
      r.ent[d.cnt].kind = kind;
      r.ent[d.cnt].ch   = (kind == K_CHAR) ? ch : 8'h00;
      r.cnt             = d.cnt + 2'd1;
    end
    return r;
  endfunction

  function automatic logic is_sep(logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChCr) || (c == ChLf);
  endfunction

endpackage

>>> rtl/slt_front.sv
// Front end: parses each accepted byte and forms the list of results it causes.
`timescale 1ns / 1ps

module slt_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    ch,
  input  logic          end_of_line,
  input  logic [7:0]    exit_status,
  output slt_pkg::desc_t desc,
  output logic          desc_valid
);
  import slt_pkg::*;

  typedef struct packed {
    desc_t d;
    mode_t m;
  } step_t;

  mode_t mode_r, mode_nxt;

  function automatic step_t token_byte(desc_t d, logic [7:0] c);
    step_t s;
    s.d = d;
    s.m = M_TOKEN;
    if (is_sep(c)) begin
      s.d = add_res(d, K_TOKEN_END, 8'h00);
      s.m = M_IDLE;
    end else if (c == ChSquote) begin
      s.m = M_SQ;
    end else if (c == ChDquote) begin
      s.m = M_DQ;
    end else if (c == ChBslash) begin
      s.m = M_TOK_BS;
    end else if (c == ChDollar) begin
      s.m = M_TOK_DOLLAR;
    end else begin
      s.d = add_res(d, K_CHAR, c);
    end
    return s;
  endfunction

  function automatic step_t dq_byte(desc_t d, logic [7:0] c);
    step_t s;
    s.d = d;
    s.m = M_DQ;
    if (c == ChDquote) begin
      s.m = M_TOKEN;
    end else if (c == ChBslash) begin
      s.m = M_DQ_BS;
    end else if (c == ChDollar) begin
      s.m = M_DQ_DOLLAR;
    end else begin
      s.d = add_res(d, K_CHAR, c);
    end
    return s;
  endfunction

  // Decimal digits of the status, no leading zeros. Tens use a reciprocal
  // multiply that is exact for values below 100.
  logic [1:0]  hund;
  logic [6:0]  rem;
  logic [14:0] prod;
  logic [3:0]  tens;
  logic [3:0]  ones;
  desc_t       status_d;

  always_comb begin
    hund = (exit_status >= 8'd200) ? 2'd2 : ((exit_status >= 8'd100) ? 2'd1 : 2'd0);
    rem  = 7'(exit_status - 8'(hund) * 8'd100);
    prod = 15'(rem) * 15'd205;
    tens = 4'(prod >> 11);
    ones = 4'(rem - 7'(tens) * 7'd10);
    status_d = '0;
    if (hund != 2'd0) begin
      status_d = add_res(status_d, K_CHAR, ChZero + 8'(hund));
    end
    if (exit_status >= 8'd10) begin
      status_d = add_res(status_d, K_CHAR, ChZero + 8'(tens));
    end
    status_d = add_res(status_d, K_CHAR, ChZero + 8'(ones));
  end

  desc_t d;
  step_t s;

  always_comb begin
    d        = '0;
    s        = '0;
    mode_nxt = mode_r;
    if (end_of_line) begin
      if (mode_r == M_TOK_BS || mode_r == M_DQ_BS) begin
        d = add_res(d, K_CHAR, ChBslash);
      end else if (mode_r == M_TOK_DOLLAR || mode_r == M_DQ_DOLLAR) begin
        d = add_res(d, K_CHAR, ChDollar);
      end
      if (mode_r >= M_TOKEN && mode_r <= M_DQ_DOLLAR) begin
        d = add_res(d, K_TOKEN_END, 8'h00);
      end
      d        = add_res(d, K_LINE_DONE, 8'h00);
      mode_nxt = M_IDLE;
    end else begin
      case (mode_r)
        M_TOKEN: begin
          s        = token_byte(d, ch);
          d        = s.d;
          mode_nxt = s.m;
        end
        M_TOK_BS: begin
          d        = add_res(d, K_CHAR, ch);
          mode_nxt = M_TOKEN;
        end
        M_TOK_DOLLAR: begin
          if (ch == ChQmark) begin
            d        = status_d;
            mode_nxt = M_TOKEN;
          end else begin
            s        = token_byte(add_res(d, K_CHAR, ChDollar), ch);
            d        = s.d;
            mode_nxt = s.m;
          end
        end
        M_SQ: begin
          if (ch == ChSquote) begin
            mode_nxt = M_TOKEN;
          end else begin
            d = add_res(d, K_CHAR, ch);
          end
        end
        M_DQ: begin
          s        = dq_byte(d, ch);
          d        = s.d;
          mode_nxt = s.m;
        end
        M_DQ_BS: begin
          if (ch == ChLowerN) begin
            d = add_res(d, K_CHAR, ChLf);
          end else if (ch == ChLowerT) begin
            d = add_res(d, K_CHAR, ChTab);
          end else begin
            d = add_res(d, K_CHAR, ch);
          end
          mode_nxt = M_DQ;
        end
        M_DQ_DOLLAR: begin
          if (ch == ChQmark) begin
            d        = status_d;
            mode_nxt = M_DQ;
          end else begin
            s        = dq_byte(add_res(d, K_CHAR, ChDollar), ch);
            d        = s.d;
            mode_nxt = s.m;
          end
        end
        M_COMMENT: begin
          mode_nxt = M_COMMENT;
        end
        default: begin
          if (is_sep(ch)) begin
            mode_nxt = M_IDLE;
          end else if (ch == ChHash) begin
            mode_nxt = M_COMMENT;
          end else begin
            s        = token_byte(d, ch);
            d        = s.d;
            mode_nxt = s.m;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
    end else if (accept) begin
      mode_r <= mode_nxt;
    end
  end

  assign desc       = d;
  assign desc_valid = accept && (d.cnt != 2'd0);

endmodule

>>> rtl/slt_queue.sv
// Short queue of result lists between the front end and the back end.
`timescale 1ns / 1ps

module slt_queue #(
  parameter int DEPTH = slt_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  slt_pkg::desc_t wr_data,
  input  logic           rd_en,
  output slt_pkg::desc_t rd_data,
  output logic           full,
  output logic           empty
);
  import slt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  desc_t         mem_r [DEPTH];
  logic [AW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] count_r;

  function automatic logic [AW-1:0] wrap_inc(logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (wr_en) begin
        wptr_r <= wrap_inc(wptr_r);
      end
      if (rd_en) begin
        rptr_r <= wrap_inc(rptr_r);
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + CW'(1);
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

>>> rtl/slt_back.sv
// Back end: walks each queued result list and issues one result per cycle while pop is held high.
`timescale 1ns / 1ps

module slt_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  slt_pkg::desc_t q_head,
  output logic           q_pop,
  input  logic           pop,
  output logic           empty,
  output logic [1:0]     out_kind,
  output logic [7:0]     out_char,
  output logic           out_last
);
  import slt_pkg::*;

  logic       valid_r, valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  res_t       res_r;
  logic       last_r;
  logic       advance, load, is_last;

  assign advance = !valid_r || pop;
  assign load    = advance && !q_empty;
  assign is_last = (idx_r == q_head.cnt - 2'd1);
  assign q_pop   = load && is_last;

  always_comb begin
    valid_nxt = advance ? !q_empty : valid_r;
    idx_nxt   = idx_r;
    if (load) begin
      idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= q_head.ent[idx_r];
      last_r <= is_last;
    end
  end

  assign empty    = !valid_r;
  assign out_kind = res_r.kind;
  assign out_char = res_r.ch;
  assign out_last = last_r;

endmodule

>>> rtl/shell_line_tokenizer.sv
// Top level of the shell line tokenizer: configuration register and the front/back pipeline.
`timescale 1ns / 1ps

// The tokenizer splits a command line, fed one byte per request, into token
// characters, token-end marks and a line-done mark, honoring single quotes,
// double quotes with backslash escapes, outside backslashes, comments that
// start at a token boundary, and $? expansion from the exit_status register.
// A byte is taken every cycle while push is high and full is low; the front
// end parses it in that same cycle and places the one to three results it
// causes into a short queue (QUEUE_DEPTH entries). The back end delivers
// one result per cycle while pop is held high, from a registered output, so
// each of the several results that a byte may cause (three status digits, or
// a held character, a token end and a line done) takes its own turn on the
// output and the queue absorbs the burst. Bytes that cause no result never
// reach the queue. The first result of a byte passes through the queue entry
// and then the output register before it appears. exit_status is at byte
// address 0 and must only be written while the block is idle.

module shell_line_tokenizer #(
  parameter int QUEUE_DEPTH = slt_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_ch,
  input  logic        in_end_of_line,
  // Result channel.
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_char,
  output logic        out_last,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import slt_pkg::*;

  logic [7:0] status_r;
  logic       accept;
  desc_t      f_desc;
  logic       f_valid;
  desc_t      q_head;
  logic       q_full, q_empty, q_pop;

  // There is a single register, so every completed write lands in it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= 8'd0;
    end else if (psel && penable && pwrite && pready) begin
      status_r <= pwdata[7:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == AddrExitStatus) ? {24'd0, status_r} : 32'd0;

  // A request is taken only while the queue can hold its results.
  assign full   = q_full;
  assign accept = push && !full;

  slt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .ch         (in_ch),
    .end_of_line(in_end_of_line),
    .exit_status(status_r),
    .desc       (f_desc),
    .desc_valid (f_valid)
  );

  slt_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (f_valid),
    .wr_data(f_desc),
    .rd_en  (q_pop),
    .rd_data(q_head),
    .full   (q_full),
    .empty  (q_empty)
  );

  slt_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .out_kind(out_kind),
    .out_char(out_char),
    .out_last(out_last)
  );

endmodule
